/* design/asfo_pkg.sv */
// ----------------------------------------------------------------------------
// asfo_pkg
// Shared widths, register indexes, reset values and control types for the
// silence skip and fade-out core.
// ----------------------------------------------------------------------------
package asfo_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int PLAY_W    = 31;
    localparam int FADE_W    = 24;
    localparam int SILENCE_W = 24;
    localparam int POS_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 31;
    localparam int PROD_W    = SAMPLE_W + FADE_W;

    // one quotient bit per divider step
    localparam int DIV_STEPS = SAMPLE_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FINITE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE = 3'd4;

    // register reset values
    localparam logic                 FINITE_RST  = 1'b1;
    localparam logic                 SKIP_RST    = 1'b0;
    localparam logic [PLAY_W-1:0]    PLAY_RST    = '0;
    localparam logic [FADE_W-1:0]    FADE_RST    = '0;
    localparam logic [SILENCE_W-1:0] SILENCE_RST = 24'd1323000;

    // run phase codes
    localparam logic [1:0] PH_SKIP = 2'd0;
    localparam logic [1:0] PH_PLAY = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;

    // outcome of evaluating one request
    typedef enum logic [1:0] {
        ACT_DROP,
        ACT_PASS,
        ACT_FADE,
        ACT_TIMEOUT
    } act_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic mul;
        logic div_step;
        logic store;
        logic out_load;
        logic chan;
    } ctl_cmd_t;

    typedef struct packed {
        act_t act;
    } ctl_stat_t;

endpackage

/* design/audio_silence_skip_and_fade_out_core.sv */
// ----------------------------------------------------------------------------
// audio_silence_skip_and_fade_out_core
// Stereo frame stage that trims leading silence, limits play length and
// applies a linear fade-out with truncating division.
//
//   channel  | ports                               | handshake
//   ---------+-------------------------------------+-----------------
//   input    | s_cmd, s_in_left, s_in_right        | s_valid/s_ready
//   result   | m_out_left, m_out_right, m_status   | m_valid/m_ready
//   config   | cfg_index, cfg_wdata                | cfg_we
//
// A dropped request or rewind ends at evaluation, a full-level frame or timeout
// goes to the output register, a faded frame first runs the 16-step restoring
// divider once for each channel. One request is in work at a time; the next is
// accepted while the previous result waits in the output register.
// Reset is synchronous, active low, and restores the configuration, the run
// state and the handshake registers; payload registers are loaded before use.
// A stall on m_ready holds a finished result in the sequencer until the
// output register frees up.
// ----------------------------------------------------------------------------
module audio_silence_skip_and_fade_out_core import asfo_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_cmd,
    input  logic signed [SAMPLE_W-1:0] s_in_left,
    input  logic signed [SAMPLE_W-1:0] s_in_right,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_out_left,
    output logic signed [SAMPLE_W-1:0] m_out_right,
    output logic                       m_status
);

    ctl_cmd_t  ctl;
    ctl_stat_t stat;

    asfo_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .ctl     (ctl)
    );

    asfo_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_cmd       (s_cmd),
        .s_in_left   (s_in_left),
        .s_in_right  (s_in_right),
        .ctl         (ctl),
        .stat        (stat),
        .m_out_left  (m_out_left),
        .m_out_right (m_out_right),
        .m_status    (m_status)
    );

endmodule

/* design/asfo_datapath.sv */
// ----------------------------------------------------------------------------
// asfo_datapath
// Configuration registers, run state, fade multiplier, shared restoring
// divider and result registers.
// ----------------------------------------------------------------------------
module asfo_datapath import asfo_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                       s_cmd,
    input  logic signed [SAMPLE_W-1:0] s_in_left,
    input  logic signed [SAMPLE_W-1:0] s_in_right,
    input  ctl_cmd_t                   ctl,
    output ctl_stat_t                  stat,
    output logic signed [SAMPLE_W-1:0] m_out_left,
    output logic signed [SAMPLE_W-1:0] m_out_right,
    output logic                       m_status
);

    logic                 finite_reg;
    logic                 skip_reg;
    logic [PLAY_W-1:0]    play_reg;
    logic [FADE_W-1:0]    fade_reg;
    logic [SILENCE_W-1:0] limit_reg;

    logic [1:0]           phase_reg, phase_next;
    logic [SILENCE_W-1:0] silent_reg, silent_next;
    logic [POS_W-1:0]     pos_reg, pos_next;

    logic                 cmd_reg;
    logic [SAMPLE_W-1:0]  left_reg, right_reg;
    logic [FADE_W-1:0]    cur_reg;
    logic [FADE_W-1:0]    rem_reg;
    logic [SAMPLE_W-1:0]  dq_reg;
    logic                 neg_reg;
    logic [SAMPLE_W-1:0]  res_left_reg, res_right_reg;
    logic                 res_status_reg;
    logic [SAMPLE_W-1:0]  out_left_reg, out_right_reg;
    logic                 out_status_reg;

    logic                 skipping, zero_frame, play_go;
    logic [SILENCE_W-1:0] silent_inc;
    logic [POS_W-1:0]     total;
    logic [FADE_W-1:0]    cur_next;
    act_t                 act;

    logic [SAMPLE_W-1:0]  sel_sample, sel_mag;
    logic [PROD_W-1:0]    prod;
    logic [FADE_W:0]      trial, trial_diff;
    logic                 trial_ge;
    logic [SAMPLE_W-1:0]  quot;

    // ------------------------------------------------------------ evaluation
    assign total      = POS_W'({1'b0, play_reg}) + POS_W'(fade_reg);
    assign cur_next   = total[FADE_W-1:0] - pos_reg[FADE_W-1:0];
    assign skipping   = (phase_reg == PH_SKIP) && skip_reg;
    assign zero_frame = (left_reg == '0) && (right_reg == '0);
    assign silent_inc = silent_reg + SILENCE_W'(1);

    always_comb begin
        act         = ACT_DROP;
        phase_next  = phase_reg;
        silent_next = silent_reg;
        pos_next    = pos_reg;
        play_go     = 1'b0;
        if (cmd_reg) begin
            // rewind
            phase_next  = PH_SKIP;
            silent_next = '0;
            pos_next    = '0;
        end else if ((phase_reg == PH_SKIP) || (phase_reg == PH_PLAY)) begin
            play_go = 1'b1;
            if (skipping) begin
                priority if (silent_reg >= limit_reg) begin
                    act        = ACT_TIMEOUT;
                    phase_next = PH_DONE;
                    play_go    = 1'b0;
                end else if (zero_frame) begin
                    silent_next = silent_inc;
                    play_go     = 1'b0;
                    if (silent_inc >= limit_reg) begin
                        act        = ACT_TIMEOUT;
                        phase_next = PH_DONE;
                    end
                end else begin
                    phase_next = PH_PLAY;
                end
            end
            if (play_go && !(finite_reg && (pos_reg >= total))) begin
                if (pos_reg != '1) begin
                    pos_next = pos_reg + POS_W'(1);
                end
                act = (finite_reg && (pos_reg > POS_W'({1'b0, play_reg}))) ?
                      ACT_FADE : ACT_PASS;
            end
        end
    end

    assign stat.act = act;

    // ------------------------------------------------------- multiply/divide
    assign sel_sample = ctl.chan ? right_reg : left_reg;
    assign sel_mag    = sel_sample[SAMPLE_W-1] ? (~sel_sample + SAMPLE_W'(1)) : sel_sample;
    assign prod       = PROD_W'(sel_mag) * PROD_W'(cur_reg);

    assign trial      = {rem_reg, dq_reg[SAMPLE_W-1]};
    assign trial_ge   = trial >= {1'b0, fade_reg};
    assign trial_diff = trial - {1'b0, fade_reg};
    assign quot       = neg_reg ? (~dq_reg + SAMPLE_W'(1)) : dq_reg;

    // ---------------------------------------------------------- control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            finite_reg <= FINITE_RST;
            skip_reg   <= SKIP_RST;
            play_reg   <= PLAY_RST;
            fade_reg   <= FADE_RST;
            limit_reg  <= SILENCE_RST;
            phase_reg  <= PH_SKIP;
            silent_reg <= '0;
            pos_reg    <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_FINITE:  finite_reg <= cfg_wdata[0];
                    CFG_SKIP:    skip_reg   <= cfg_wdata[0];
                    CFG_PLAY:    play_reg   <= cfg_wdata[PLAY_W-1:0];
                    CFG_FADE:    fade_reg   <= cfg_wdata[FADE_W-1:0];
                    CFG_SILENCE: limit_reg  <= cfg_wdata[SILENCE_W-1:0];
                    default: ;
                endcase
            end
            if (ctl.eval) begin
                phase_reg  <= phase_next;
                silent_reg <= silent_next;
                pos_reg    <= pos_next;
            end
        end
    end

    // --------------------------------------------------------------- payload
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            cmd_reg   <= s_cmd;
            left_reg  <= s_in_left;
            right_reg <= s_in_right;
        end
        if (ctl.eval) begin
            cur_reg <= cur_next;
            unique case (act)
                ACT_TIMEOUT: begin
                    res_left_reg   <= '0;
                    res_right_reg  <= '0;
                    res_status_reg <= 1'b1;
                end
                ACT_PASS: begin
                    res_left_reg   <= left_reg;
                    res_right_reg  <= right_reg;
                    res_status_reg <= 1'b0;
                end
                ACT_FADE: res_status_reg <= 1'b0;
                default: ;
            endcase
        end
        if (ctl.mul) begin
            // upper product bits seed the remainder, always below the divisor
            rem_reg <= prod[PROD_W-1:SAMPLE_W];
            dq_reg  <= prod[SAMPLE_W-1:0];
            neg_reg <= sel_sample[SAMPLE_W-1];
        end
        if (ctl.div_step) begin
            rem_reg <= trial_ge ? trial_diff[FADE_W-1:0] : trial[FADE_W-1:0];
            dq_reg  <= {dq_reg[SAMPLE_W-2:0], trial_ge};
        end
        if (ctl.store) begin
            if (ctl.chan) begin
                res_right_reg <= quot;
            end else begin
                res_left_reg <= quot;
            end
        end
        if (ctl.out_load) begin
            out_left_reg   <= res_left_reg;
            out_right_reg  <= res_right_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign m_out_left  = out_left_reg;
    assign m_out_right = out_right_reg;
    assign m_status    = out_status_reg;

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.div_step |-> (rem_reg < fade_reg))
        else $error("divider remainder not below fade length");

endmodule

/* design/asfo_ctrl.sv */
// ----------------------------------------------------------------------------
// asfo_ctrl
// Sequencer: takes a request, evaluates it, runs the fade divider once per
// channel for a faded frame and hands any result to the output register.
// ----------------------------------------------------------------------------
module asfo_ctrl import asfo_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  ctl_stat_t stat,
    output ctl_cmd_t  ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MUL,
        S_DIV,
        S_STORE,
        S_FINISH
    } state_t;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 chan_reg, chan_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 slot_free;

    assign slot_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        chan_next  = chan_reg;
        ctl        = '0;
        ctl.chan   = chan_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    ctl.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                ctl.eval = 1'b1;
                unique case (stat.act)
                    ACT_DROP: state_next = S_IDLE;
                    ACT_FADE: begin
                        chan_next  = 1'b0;
                        state_next = S_MUL;
                    end
                    default: state_next = S_FINISH;
                endcase
            end
            S_MUL: begin
                ctl.mul    = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                ctl.div_step = 1'b1;
                cnt_next     = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_LAST) begin
                    state_next = S_STORE;
                end
            end
            S_STORE: begin
                ctl.store = 1'b1;
                if (chan_reg) begin
                    state_next = S_FINISH;
                end else begin
                    chan_next  = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_FINISH: begin
                // hold the result until the output register frees up
                if (slot_free) begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (ctl.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            chan_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            chan_reg    <= chan_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.out_load |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before it was taken");

    a_accept_evals: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_EVAL))
        else $error("accepted request not evaluated next");

    a_div_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV && cnt_reg == DIV_LAST) |=> (state_reg == S_STORE))
        else $error("divider ran past its last step");

endmodule

/* verif/asfo_tb_pkg.sv */
// ----------------------------------------------------------------------------
// asfo_tb_pkg
// Request and result codes shared by the stimulus and the checker of the
// silence skip and fade-out core.
// ----------------------------------------------------------------------------
package asfo_tb_pkg;

    localparam logic CMD_FRAME  = 1'b0;
    localparam logic CMD_REWIND = 1'b1;

    localparam logic ST_AUDIO   = 1'b0;
    localparam logic ST_TIMEOUT = 1'b1;

endpackage

/* verif/asfo_frame_checker.sv */
// ----------------------------------------------------------------------------
// asfo_frame_checker
// Watches the config port and both streams of the silence skip and fade-out
// core, predicts each output frame from the accepted requests and compares
// every returned frame against the oldest prediction.
// ----------------------------------------------------------------------------
module asfo_frame_checker import asfo_pkg::*; import asfo_tb_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic                       s_cmd,
    input  logic signed [SAMPLE_W-1:0] s_in_left,
    input  logic signed [SAMPLE_W-1:0] s_in_right,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic signed [SAMPLE_W-1:0] m_out_left,
    input  logic signed [SAMPLE_W-1:0] m_out_right,
    input  logic                       m_status,
    output int                         mismatch_count,
    output int                         frames_pending
);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       status;
    } frame_t;

    logic                 finite_en;
    logic                 skip_en;
    logic [PLAY_W-1:0]    play_len;
    logic [FADE_W-1:0]    fade_span;
    logic [SILENCE_W-1:0] sil_limit;

    logic [1:0]           run_phase;
    logic [SILENCE_W-1:0] silent_cnt;
    logic [POS_W-1:0]     frame_pos;

    frame_t expected_frames[$];
    int     errs = 0;

    function automatic logic signed [SAMPLE_W-1:0] fade_scale(
        input logic signed [SAMPLE_W-1:0] s,
        input logic [POS_W-1:0]           level
    );
        longint prod;
        longint quo;
        prod = longint'(s) * longint'(level);
        // signed division truncates toward zero
        quo = prod / longint'(fade_span);
        return quo[SAMPLE_W-1:0];
    endfunction

    function automatic bit predict_frame(
        input  logic                       cmd,
        input  logic signed [SAMPLE_W-1:0] l,
        input  logic signed [SAMPLE_W-1:0] r,
        output frame_t                     res
    );
        logic [POS_W:0]   end_pos;
        logic [POS_W-1:0] n;
        logic [POS_W-1:0] level;
        bit               timed_out;
        res = '0;
        timed_out = 1'b0;
        if (cmd == CMD_REWIND) begin
            run_phase = PH_SKIP;
            silent_cnt = '0;
            frame_pos = '0;
            return 1'b0;
        end
        // finished, including the unused phase code
        if (run_phase >= PH_DONE)
            return 1'b0;
        if (run_phase == PH_SKIP && skip_en) begin
            if (silent_cnt >= sil_limit) begin
                timed_out = 1'b1;
            end else if (l == 0 && r == 0) begin
                silent_cnt = silent_cnt + 1'b1;
                if (silent_cnt >= sil_limit)
                    timed_out = 1'b1;
                else
                    return 1'b0;
            end
            if (timed_out) begin
                run_phase = PH_DONE;
                res.status = ST_TIMEOUT;
                return 1'b1;
            end
            run_phase = PH_PLAY;
        end
        end_pos = (POS_W+1)'(play_len) + (POS_W+1)'(fade_span);
        n = frame_pos;
        if (finite_en && {1'b0, n} >= end_pos)
            return 1'b0;
        if (frame_pos != '1)
            frame_pos = frame_pos + 1'b1;
        if (finite_en && n > play_len) begin
            level = POS_W'(end_pos - {1'b0, n});
            res.left = fade_scale(l, level);
            res.right = fade_scale(r, level);
        end else begin
            res.left = l;
            res.right = r;
        end
        res.status = ST_AUDIO;
        return 1'b1;
    endfunction

    always @(posedge aclk) begin
        frame_t want;
        frame_t got;
        frame_t res;
        if (!aresetn) begin
            finite_en = FINITE_RST;
            skip_en = SKIP_RST;
            play_len = PLAY_RST;
            fade_span = FADE_RST;
            sil_limit = SILENCE_RST;
            run_phase = PH_SKIP;
            silent_cnt = '0;
            frame_pos = '0;
            expected_frames.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_FINITE:  finite_en = cfg_wdata[0];
                    CFG_SKIP:    skip_en = cfg_wdata[0];
                    CFG_PLAY:    play_len = cfg_wdata[PLAY_W-1:0];
                    CFG_FADE:    fade_span = cfg_wdata[FADE_W-1:0];
                    CFG_SILENCE: sil_limit = cfg_wdata[SILENCE_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (predict_frame(s_cmd, s_in_left, s_in_right, res))
                    expected_frames.push_back(res);
            end
            if (m_valid && m_ready) begin
                got = '{left: m_out_left, right: m_out_right, status: m_status};
                if (expected_frames.size() == 0) begin
                    errs++;
                    $display({"%0t: unexpected frame: expected none,",
                              " got L=%0d R=%0d status=%0b"},
                             $time, got.left, got.right, got.status);
                end else begin
                    want = expected_frames.pop_front();
                    if (got !== want) begin
                        errs++;
                        $display({"%0t: frame mismatch: expected L=%0d R=%0d status=%0b,",
                                  " got L=%0d R=%0d status=%0b"}, $time,
                                 want.left, want.right, want.status,
                                 got.left, got.right, got.status);
                    end
                end
            end
        end
        mismatch_count <= errs;
        frames_pending <= expected_frames.size();
    end

endmodule

/* verif/tb_audio_silence_skip_and_fade_out_core.sv */
// ----------------------------------------------------------------------------
// tb_audio_silence_skip_and_fade_out_core
// Drives frames and rewinds into the silence skip and fade-out core under a
// series of register settings, with random gaps and back-pressure, and leaves
// the checking of every output frame to asfo_frame_checker.
// ----------------------------------------------------------------------------
module tb_audio_silence_skip_and_fade_out_core;
    import asfo_pkg::*;
    import asfo_tb_pkg::*;

    localparam int ITEM_TARGET = 1350;

    typedef enum {
        MODE_SHORT,
        MODE_ENDLESS,
        MODE_HUGE,
        MODE_DEEP_FADE,
        MODE_NO_FADE
    } mode_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_wdata = '0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic                       s_cmd = CMD_FRAME;
    logic signed [SAMPLE_W-1:0] s_in_left = '0;
    logic signed [SAMPLE_W-1:0] s_in_right = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] m_out_left;
    logic signed [SAMPLE_W-1:0] m_out_right;
    logic                       m_status;

    int mismatch_count;
    int frames_pending;
    int sent = 0;
    bit quiet = 1'b0;
    bit sink_hold = 1'b0;

    // current settings, used to shape the request sequences
    logic                 skip_mode = SKIP_RST;
    logic [PLAY_W-1:0]    play_len = PLAY_RST;
    logic [FADE_W-1:0]    fade_span = FADE_RST;
    logic [SILENCE_W-1:0] sil_limit = SILENCE_RST;

    always #1 aclk = ~aclk;

    audio_silence_skip_and_fade_out_core u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_in_left   (s_in_left),
        .s_in_right  (s_in_right),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_left  (m_out_left),
        .m_out_right (m_out_right),
        .m_status    (m_status)
    );

    asfo_frame_checker u_chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_in_left      (s_in_left),
        .s_in_right     (s_in_right),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_left     (m_out_left),
        .m_out_right    (m_out_right),
        .m_status       (m_status),
        .mismatch_count (mismatch_count),
        .frames_pending (frames_pending)
    );

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return -16'sd1;
            3: return 16'sd1;
            4: return 16'sd0;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic offer(input logic cmd, input logic signed [SAMPLE_W-1:0] l,
                         input logic signed [SAMPLE_W-1:0] r);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_in_left <= l;
        s_in_right <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    task automatic send_frame(input logic signed [SAMPLE_W-1:0] l,
                              input logic signed [SAMPLE_W-1:0] r);
        offer(CMD_FRAME, l, r);
    endtask

    task automatic send_rewind();
        offer(CMD_REWIND, 16'($urandom()), 16'($urandom()));
    endtask

    // hold requests until every frame is back and the core has gone quiet
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (frames_pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic load_config(input logic fin, input logic skip,
                               input logic [PLAY_W-1:0] play,
                               input logic [FADE_W-1:0] fade,
                               input logic [SILENCE_W-1:0] sil);
        skip_mode = skip;
        play_len = play;
        fade_span = fade;
        sil_limit = sil;
        cfg_we <= 1'b1;
        cfg_index <= CFG_FINITE;
        cfg_wdata <= CFG_DATA_W'({$urandom(), fin});
        @(posedge aclk);
        cfg_index <= CFG_SKIP;
        cfg_wdata <= CFG_DATA_W'({$urandom(), skip});
        @(posedge aclk);
        cfg_index <= CFG_PLAY;
        cfg_wdata <= play;
        @(posedge aclk);
        cfg_index <= CFG_FADE;
        cfg_wdata <= CFG_DATA_W'({$urandom(), fade});
        @(posedge aclk);
        cfg_index <= CFG_SILENCE;
        cfg_wdata <= CFG_DATA_W'({$urandom(), sil});
        @(posedge aclk);
        // unmapped indexes must not disturb anything
        for (int i = CFG_SILENCE + 1; i < 2 ** CFG_IDX_W; i++) begin
            cfg_index <= CFG_IDX_W'(i);
            cfg_wdata <= CFG_DATA_W'($urandom());
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    // optional rewind, leading silence in skip mode, first audible frame, then a run into the fade
    task automatic run_sequence();
        int silent_n;
        int tail_n;
        longint span;
        logic signed [SAMPLE_W-1:0] l;
        logic signed [SAMPLE_W-1:0] r;
        if ($urandom_range(0, 6) != 0)
            send_rewind();
        if (skip_mode) begin
            silent_n = $urandom_range(0, (sil_limit > 7) ? 8 : int'(sil_limit) + 1);
            repeat (silent_n) send_frame('0, '0);
        end
        l = rand_sample();
        r = rand_sample();
        if (l == 0 && r == 0)
            r = 16'($urandom_range(1, 65535));
        send_frame(l, r);
        span = longint'(play_len) + longint'(fade_span) + 2;
        if (span > 24)
            span = 24;
        tail_n = $urandom_range(0, int'(span));
        repeat (tail_n) begin
            case ($urandom_range(0, 19))
                0: send_frame('0, '0);
                1: send_rewind();
                default: send_frame(rand_sample(), rand_sample());
            endcase
        end
    endtask

    always begin
        if (sink_hold) begin
            m_ready <= 1'b0;
            repeat (300) @(posedge aclk);
            sink_hold = 1'b0;
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
            m_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end else begin
            m_ready <= 1'b1;
            repeat (quiet ? 1 : $urandom_range(1, 10)) @(posedge aclk);
        end
    end

    initial begin
        #1_000_000;
        $display("tb_audio_silence_skip_and_fade_out_core: errors");
        $finish;
    end

    initial begin
        mode_t mode;
        int    ph;
        int    phase_end;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings give a zero-length run: everything is dropped
        send_frame(16'sh7FFF, 16'sh8000);
        send_rewind();

        settle();
        load_config(1'b1, 1'b1, 31'd2, 24'd4, 24'd3);
        send_frame('0, '0);
        send_frame('0, '0);
        send_frame(16'sd0, 16'sd1);
        send_frame(16'sh7FFF, 16'sh8000);
        send_frame(16'sh8000, 16'sh7FFF);
        send_frame(16'sh8000, 16'sh8000);
        send_frame(-16'sd1, 16'sd1);
        send_frame(16'sh7FFF, 16'sh8000);
        send_frame(16'sd9, 16'sd9);
        send_rewind();
        send_frame('0, '0);
        send_frame('0, '0);
        send_frame('0, '0);
        send_frame(16'sd5, 16'sd5);
        send_rewind();

        // a zero limit times out on the first frame, audible or not
        settle();
        load_config(1'b1, 1'b1, 31'd2, 24'd4, 24'd0);
        send_frame(16'sd7, 16'sd0);
        send_frame(16'sd3, 16'sd3);
        send_rewind();

        settle();
        load_config(1'b0, 1'b0, '1, '1, '1);
        send_frame('0, '0);
        send_frame(16'sh8000, 16'sh7FFF);

        for (ph = 0; sent < ITEM_TARGET; ph++) begin
            settle();
            quiet = (sent >= ITEM_TARGET - 150);
            case ($urandom_range(0, 9))
                0: mode = MODE_ENDLESS;
                1: mode = MODE_HUGE;
                2: mode = MODE_DEEP_FADE;
                3: mode = MODE_NO_FADE;
                default: mode = MODE_SHORT;
            endcase
            if (ph == 2)
                mode = MODE_ENDLESS;
            case (mode)
                MODE_ENDLESS:
                    load_config(1'b0, 1'($urandom()), 31'($urandom()), 24'($urandom()),
                                24'($urandom_range(0, 8)));
                MODE_HUGE:
                    load_config(1'b1, 1'($urandom()), '1, '1,
                                $urandom_range(0, 1) ? {SILENCE_W{1'b1}} : {SILENCE_W{1'b0}});
                MODE_DEEP_FADE:
                    load_config(1'b1, 1'($urandom()), '0, '1, 24'($urandom_range(0, 8)));
                MODE_NO_FADE:
                    load_config(1'b1, 1'($urandom()), 31'($urandom_range(0, 12)), '0,
                                24'($urandom_range(0, 8)));
                default:
                    load_config(1'b1, 1'($urandom()), 31'($urandom_range(0, 12)),
                                24'($urandom_range(1, 24)), 24'($urandom_range(0, 8)));
            endcase
            // stall the output long enough for requests to back up
            if (ph == 2)
                sink_hold = 1'b1;
            phase_end = sent + 30 + $urandom_range(0, 20);
            while (sent < phase_end) run_sequence();
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        for (int k = 0; k < 50000 && frames_pending != 0; k++) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0 && frames_pending == 0)
            $display("tb_audio_silence_skip_and_fade_out_core: clean");
        else
            $display("tb_audio_silence_skip_and_fade_out_core: errors");
        $finish;
    end

endmodule
